// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the coalescer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Implication checked from one clock edge to the next.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/mmrc_pkg.sv -----
// Types, constants and class codes of the memory map range coalescer.
package mmrc_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int HELD_W      = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W       = 5;
	localparam int CNT_W       = 6;
	localparam int SIZE_W      = 13;
	localparam int PAGE_W      = 52;
	localparam int PAGE_SHIFT  = 12;

	localparam logic [HELD_W-1:0] MAX_HELD      = HELD_W'(MAX_ENTRIES);
	localparam logic [SIZE_W-1:0] MIN_DESC_SIZE = SIZE_W'(32);
	localparam logic [SIZE_W-1:0] RESET_DESC_SIZE = SIZE_W'(48);

	// E820 classes.
	localparam logic [2:0] E820_NONE     = 3'd0;
	localparam logic [2:0] E820_USABLE   = 3'd1;
	localparam logic [2:0] E820_RESERVED = 3'd2;
	localparam logic [2:0] E820_ACPI     = 3'd3;
	localparam logic [2:0] E820_NVS      = 3'd4;
	localparam logic [2:0] E820_UNUSABLE = 3'd5;

	// UEFI memory types that map to something other than reserved.
	localparam logic [31:0] EFI_LOADER_CODE   = 32'd1;
	localparam logic [31:0] EFI_LOADER_DATA   = 32'd2;
	localparam logic [31:0] EFI_BOOT_CODE     = 32'd3;
	localparam logic [31:0] EFI_BOOT_DATA     = 32'd4;
	localparam logic [31:0] EFI_CONVENTIONAL  = 32'd7;
	localparam logic [31:0] EFI_UNUSABLE      = 32'd8;
	localparam logic [31:0] EFI_ACPI_RECLAIM  = 32'd9;
	localparam logic [31:0] EFI_ACPI_NVS      = 32'd10;
	localparam logic [31:0] EFI_PERSISTENT    = 32'd14;

	typedef struct packed {
		logic              start_of_map;
		logic              last_descriptor;
		logic [63:0]       phys_base;
		logic [PAGE_W-1:0] page_count;
		logic [31:0]       efi_type;
	} desc_t;

	typedef struct packed {
		logic             entry_valid;
		logic             entry_merged;
		logic [IDX_W-1:0] entry_index;
		logic [63:0]      entry_base;
		logic [63:0]      entry_length;
		logic [2:0]       e820_class;
		logic [CNT_W-1:0] entry_count;
	} entry_t;

	typedef struct packed {
		logic step;
		logic size_ok;
	} ctl_t;

endpackage

// ----- hw/rtl/mmrc_if.sv -----
// Descriptor and entry channel interfaces of the coalescer.
interface mmrc_desc_if;
	logic        valid;
	logic        ready;
	logic        start_of_map;
	logic        last_descriptor;
	logic [63:0] phys_base;
	logic [51:0] page_count;
	logic [31:0] efi_type;

	modport source (output valid, start_of_map, last_descriptor, phys_base, page_count,
		efi_type, input ready);
	modport sink (input valid, start_of_map, last_descriptor, phys_base, page_count,
		efi_type, output ready);
endinterface

interface mmrc_entry_if;
	logic        valid;
	logic        ready;
	logic        entry_valid;
	logic        entry_merged;
	logic [4:0]  entry_index;
	logic [63:0] entry_base;
	logic [63:0] entry_length;
	logic [2:0]  e820_class;
	logic [5:0]  entry_count;

	modport source (output valid, entry_valid, entry_merged, entry_index, entry_base,
		entry_length, e820_class, entry_count, input ready);
	modport sink (input valid, entry_valid, entry_merged, entry_index, entry_base,
		entry_length, e820_class, entry_count, output ready);
endinterface

// ----- hw/rtl/mmrc_class_map.sv -----
// Maps a UEFI memory type to its E820 class.
module mmrc_class_map
	import mmrc_pkg::*;
(
	input  logic [31:0] efi_type,
	output logic [2:0]  e820_class
);

	always_comb begin
		unique case (efi_type)
			EFI_LOADER_CODE, EFI_LOADER_DATA, EFI_BOOT_CODE, EFI_BOOT_DATA,
			EFI_CONVENTIONAL, EFI_PERSISTENT: e820_class = E820_USABLE;
			EFI_ACPI_RECLAIM: e820_class = E820_ACPI;
			EFI_ACPI_NVS:     e820_class = E820_NVS;
			EFI_UNUSABLE:     e820_class = E820_UNUSABLE;
			default:          e820_class = E820_RESERVED;
		endcase
	end

endmodule

// ----- hw/rtl/mmrc_merge_core.sv -----
// Previous-entry state and the merge or append decision for one descriptor.
module mmrc_merge_core
	import mmrc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  ctl_t   ctl,
	input  desc_t  desc,
	output entry_t result
);
`include "assert_macros.svh"

	logic [63:0]       prev_base_q;
	logic [63:0]       prev_len_q;
	logic [2:0]        prev_cls_q;
	logic [HELD_W-1:0] held_q;

	logic [63:0]       eff_base;
	logic [63:0]       eff_len;
	logic [2:0]        eff_cls;
	logic [HELD_W-1:0] eff_held;

	logic [63:0]       length;
	logic [2:0]        cls;
	logic              take;
	logic              merge;
	logic [63:0]       nxt_base;
	logic [63:0]       nxt_len;
	logic [2:0]        nxt_cls;
	logic [HELD_W-1:0] nxt_held;
	logic [HELD_W-1:0] idx_full;

	mmrc_class_map u_class_map (
		.efi_type   (desc.efi_type),
		.e820_class (cls)
	);

	// A start-of-map descriptor sees an empty map.
	assign eff_base = desc.start_of_map ? 64'd0 : prev_base_q;
	assign eff_len  = desc.start_of_map ? 64'd0 : prev_len_q;
	assign eff_cls  = desc.start_of_map ? E820_NONE : prev_cls_q;
	assign eff_held = desc.start_of_map ? '0 : held_q;

	assign length = {desc.page_count, {PAGE_SHIFT{1'b0}}};
	assign take   = ctl.size_ok && (eff_held < MAX_HELD) && (desc.page_count != '0);
	assign merge  = take && (eff_held != '0) && (eff_cls == cls)
		&& ((eff_base + eff_len) == desc.phys_base);

	always_comb begin
		nxt_base = eff_base;
		nxt_len  = eff_len;
		nxt_cls  = eff_cls;
		nxt_held = eff_held;
		idx_full = eff_held;
		if (merge) begin
			nxt_len  = eff_len + length;
			idx_full = eff_held - HELD_W'(1);
		end else if (take) begin
			nxt_base = desc.phys_base;
			nxt_len  = length;
			nxt_cls  = cls;
			nxt_held = eff_held + HELD_W'(1);
		end
	end

	always_comb begin
		result              = '0;
		result.entry_count  = CNT_W'(nxt_held);
		if (take) begin
			result.entry_valid  = 1'b1;
			result.entry_merged = merge;
			result.entry_index  = IDX_W'(idx_full);
			result.entry_base   = nxt_base;
			result.entry_length = nxt_len;
			result.e820_class   = nxt_cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_base_q <= '0;
			prev_len_q  <= '0;
			prev_cls_q  <= E820_NONE;
			held_q      <= '0;
		end else if (ctl.step) begin
			prev_base_q <= nxt_base;
			prev_len_q  <= nxt_len;
			prev_cls_q  <= nxt_cls;
			held_q      <= nxt_held;
		end
	end

	`ASSERT_ALWAYS(a_held_cap, clk, arst_n, held_q <= MAX_HELD, "entry count above cap")
	`ASSERT_ALWAYS(a_merge_needs_entry, clk, arst_n,
		!ctl.step || !merge || (eff_held != '0 && take), "merge without a held entry")
	`ASSERT_NEXT(a_ignored_keeps_state, clk, arst_n,
		ctl.step && !take && !desc.start_of_map,
		$stable(held_q) && $stable(prev_len_q) && $stable(prev_base_q),
		"ignored descriptor changed state")

endmodule

// ----- hw/rtl/memory_map_range_coalescer.sv -----
// Top level: input register, merge core and result register of the coalescer.
// A descriptor is captured in the input register, and its result in the result register.
// Throughput: one descriptor per cycle while entry.ready stays high; the merge add and
// compare sit between the input register and the result register.
// Reset clears the held entry, the entry count and the valid flags of both
// stages, and sets the descriptor size register stride_q to 48.
module memory_map_range_coalescer
	import mmrc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  logic [SIZE_W-1:0]   cfg_write_data,
	mmrc_desc_if.sink           desc,
	mmrc_entry_if.source        entry
);
`include "assert_macros.svh"

	logic [SIZE_W-1:0] stride_q;
	logic              valid_s1;
	desc_t             desc_s1;
	logic              valid_s2;
	entry_t            entry_s2;
	logic              adv;
	ctl_t              ctl;
	entry_t            result;

	// Stage 1 moves on when the result register is empty or drains this cycle.
	assign adv        = valid_s1 && (!valid_s2 || entry.ready);
	assign desc.ready = !valid_s1 || adv;

	assign ctl.step    = adv;
	assign ctl.size_ok = stride_q >= MIN_DESC_SIZE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= RESET_DESC_SIZE;
		end else if (cfg_write_en) begin
			stride_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (desc.ready) begin
				valid_s1 <= desc.valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (entry.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (desc.valid && desc.ready) begin
			desc_s1.start_of_map    <= desc.start_of_map;
			desc_s1.last_descriptor <= desc.last_descriptor;
			desc_s1.phys_base       <= desc.phys_base;
			desc_s1.page_count      <= desc.page_count;
			desc_s1.efi_type        <= desc.efi_type;
		end
		if (adv) begin
			entry_s2 <= result;
		end
	end

	mmrc_merge_core u_merge_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.desc   (desc_s1),
		.result (result)
	);

	assign entry.valid        = valid_s2;
	assign entry.entry_valid  = entry_s2.entry_valid;
	assign entry.entry_merged = entry_s2.entry_merged;
	assign entry.entry_index  = entry_s2.entry_index;
	assign entry.entry_base   = entry_s2.entry_base;
	assign entry.entry_length = entry_s2.entry_length;
	assign entry.e820_class   = entry_s2.e820_class;
	assign entry.entry_count  = entry_s2.entry_count;

	`ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !adv, valid_s1 && $stable(desc_s1),
		"stalled descriptor lost from stage 1")
	`ASSERT_NEXT(a_s2_holds, clk, arst_n, valid_s2 && !entry.ready,
		valid_s2 && $stable(entry_s2), "stalled result lost from stage 2")
	`ASSERT_NEXT(a_s2_fills, clk, arst_n, adv, valid_s2,
		"advanced descriptor left no result")

endmodule
